FILE: hw/rtl/sjf_rq_pkg.sv
// ----------------------------------------------------------------------------
// sjf_rq_pkg
// Shared types and constants of the shortest-job-first ready queue.
// ----------------------------------------------------------------------------
package sjf_rq_pkg;

  localparam int DEPTH   = 16;
  localparam int OCC_W   = $clog2(DEPTH + 1);
  localparam int ID_W    = 8;
  localparam int TIME_W  = 32;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  localparam logic REG_SHORTEST_FIRST = 1'b0;

  typedef struct packed {
    logic [TIME_W-1:0] exec_time;
    logic [ID_W-1:0]   task_id;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD_NEW,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic              occupied;
    logic              shortest_first;
    logic [TIME_W-1:0] key;
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/sjf_rq_cell.sv
// ----------------------------------------------------------------------------
// sjf_rq_cell
// One queue slot: holds an entry, compares it against the incoming key and
// extends the run of strictly larger entries toward the head.
// ----------------------------------------------------------------------------
module sjf_rq_cell
  import sjf_rq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  entry_t     new_entry,
  input  entry_t     left_entry,
  input  entry_t     right_entry,
  input  logic       run_in,
  output logic       run_out,
  output entry_t     entry
);

  entry_t entry_r;
  entry_t entry_nxt;
  logic   gt;

  assign gt      = ctrl.shortest_first && (entry_r.exec_time > ctrl.key);
  // unoccupied slots count as part of the run
  assign run_out = !ctrl.occupied || (gt && run_in);
  assign entry   = entry_r;

  always_comb begin
    unique case (ctrl.op)
      CELL_HOLD:       entry_nxt = entry_r;
      CELL_LOAD_NEW:   entry_nxt = new_entry;
      CELL_FROM_LEFT:  entry_nxt = left_entry;
      CELL_FROM_RIGHT: entry_nxt = right_entry;
      default:         entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

FILE: hw/rtl/shortest_job_first_ready_queue.sv
// ----------------------------------------------------------------------------
// shortest_job_first_ready_queue
// Ready queue of task entries kept in a row of slot cells.
// ----------------------------------------------------------------------------
// One request is taken per cycle unless the output stalls; its result appears
// in the output register the next cycle, and a new request is taken while
// that result is taken. Every slot cell compares its entry with the incoming
// key at once, so inserts and removes update all slots together at any depth.
// tuser of the input selects insert (0) or remove (1); tuser of the output is
// removed_valid. A full queue drops an insert and flags it.
module shortest_job_first_ready_queue
  import sjf_rq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input requests
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // task_id[7:0], exec_time[39:8]
  input  logic        in_tuser,   // func
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // removed_id[7:0], removed_time[39:8],
                                  // dropped[40], now_empty[41], zero[47:42]
  output logic        out_tuser,  // removed_valid
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic             sf_r;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             rvalid_r;
  entry_t           rentry_r;
  logic             dropped_r, empty_r;

  logic             accept, full, do_insert, do_remove;
  entry_t           in_entry;
  entry_t           cell_entry [DEPTH];
  logic             run        [DEPTH];
  cell_ctrl_t       ctrl       [DEPTH];

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {31'd0, sf_r & (cfg_paddr[2] == REG_SHORTEST_FIRST)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sf_r <= 1'b1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_SHORTEST_FIRST) begin
      sf_r <= cfg_pwdata[0];
    end
  end

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign in_entry  = '{exec_time: in_tdata[39:8], task_id: in_tdata[7:0]};
  assign full      = (occ_r == OCC_W'(DEPTH));
  assign do_insert = accept && (in_tuser == FUNC_INSERT) && !full;
  assign do_remove = accept && (in_tuser == FUNC_REMOVE) && (occ_r != '0);

  always_comb begin
    occ_nxt = occ_r;
    if (do_insert) begin
      occ_nxt = occ_r + OCC_W'(1);
    end else if (do_remove) begin
      occ_nxt = occ_r - OCC_W'(1);
    end
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic prev_run, run_in;
      entry_t left_e, right_e;

      if (i == 0) begin : g_head
        assign prev_run = 1'b0;
        assign left_e   = in_entry;
      end else begin : g_body
        assign prev_run = run[i-1];
        assign left_e   = cell_entry[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
        assign run_in  = 1'b1;
        assign right_e = cell_entry[i];
      end else begin : g_inner
        assign run_in  = run[i+1];
        assign right_e = cell_entry[i+1];
      end

      always_comb begin
        ctrl[i].occupied       = (occ_r > OCC_W'(i));
        ctrl[i].shortest_first = sf_r;
        ctrl[i].key            = in_entry.exec_time;
        ctrl[i].op             = CELL_HOLD;
        if (do_insert) begin
          if (run[i] && !prev_run) begin
            ctrl[i].op = CELL_LOAD_NEW;
          end else if (run[i] && prev_run && (occ_r >= OCC_W'(i))) begin
            ctrl[i].op = CELL_FROM_LEFT;
          end
        end else if (do_remove && (i != DEPTH - 1)) begin
          ctrl[i].op = CELL_FROM_RIGHT;
        end
      end

      sjf_rq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl[i]),
        .new_entry   (in_entry),
        .left_entry  (left_e),
        .right_entry (right_e),
        .run_in      (run_in),
        .run_out     (run[i]),
        .entry       (cell_entry[i])
      );
    end
  endgenerate

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rvalid_r  <= do_remove;
      rentry_r  <= do_remove ? cell_entry[0] : '0;
      dropped_r <= (in_tuser == FUNC_INSERT) && full;
      empty_r   <= (occ_nxt == '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = rvalid_r;
  assign out_tdata  = {6'd0, empty_r, dropped_r, rentry_r.exec_time, rentry_r.task_id};

endmodule
